// File: src/assert_macros.svh
// Assertion macros shared by the converter RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/itp_pkg.sv
// Shared types, constants and helper functions for the infix to postfix converter.
// No dependencies; every other file in src but assert_macros.svh imports it.
package itp_pkg;

    localparam int CHAR_W          = 8;
    localparam int CNT_W           = 8;
    localparam int UPC_W           = 5;
    localparam int STACK_DEPTH_DEF = 32;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [UPC_W-1:0]  upc_t;

    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_0      = 8'h30;
    localparam char_t CH_9      = 8'h39;
    localparam char_t CH_AT     = 8'h40;
    localparam char_t CH_UA     = 8'h41;
    localparam char_t CH_UZ     = 8'h5A;
    localparam char_t CH_LBRACK = 8'h5B;
    localparam char_t CH_RBRACK = 8'h5D;
    localparam char_t CH_LA     = 8'h61;
    localparam char_t CH_LZ     = 8'h7A;
    localparam char_t CH_NUL    = 8'h00;

    localparam cnt_t ARG_TEN     = 8'd10;
    localparam cnt_t ARG_HUNDRED = 8'd100;
    localparam cnt_t ARG_MAX     = 8'd255;

    typedef enum logic [2:0] {
        CODE_LPAREN = 3'd0,
        CODE_LBRACK = 3'd1,
        CODE_ADD    = 3'd2,
        CODE_SUB    = 3'd3,
        CODE_MUL    = 3'd4,
        CODE_DIV    = 3'd5
    } op_code_t;

    typedef enum logic [2:0] {
        CLS_ALNUM,
        CLS_LPAREN,
        CLS_LBRACK,
        CLS_RPAREN,
        CLS_RBRACK,
        CLS_COMMA,
        CLS_OP,
        CLS_OTHER
    } cls_t;

    // microcode fields
    typedef enum logic [3:0] {
        C_NEVER,
        C_NO_INPUT,
        C_IS_ALNUM,
        C_NOT_OPND,
        C_STOP_PAREN,
        C_STOP_BRACK,
        C_ARG_LT100,
        C_ARG_LT10,
        C_OP_NO_POP,
        C_NOT_END,
        C_EMPTY
    } cond_t;

    typedef enum logic [2:0] {
        E_NONE,
        E_CHAR,
        E_SPACE,
        E_TOP,
        E_AT,
        E_HUND,
        E_TENS,
        E_ONES
    } emit_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_LOAD,
        A_SET_OPND,
        A_RUNEND,
        A_PUSH,
        A_PUSH_LIST,
        A_POP,
        A_DROP_PAREN,
        A_DROP_BRACK,
        A_CLR_LIST,
        A_ARG_INC,
        A_FINISH
    } act_t;

    typedef enum logic [1:0] {
        NX_INC,
        NX_STAY,
        NX_GOTO,
        NX_DISPATCH
    } nx_t;

    typedef struct packed {
        cond_t cond;
        upc_t  tgt;
        emit_t emit;
        act_t  act;
        nx_t   nx;
    } ucode_t;

    // microprogram addresses
    localparam upc_t U_FETCH    = 5'd0;
    localparam upc_t U_CLASSIFY = 5'd1;
    localparam upc_t U_RUNEND   = 5'd2;
    localparam upc_t U_DISPATCH = 5'd3;
    localparam upc_t U_ALNUM    = 5'd4;
    localparam upc_t U_LPAREN   = 5'd5;
    localparam upc_t U_LBRACK   = 5'd6;
    localparam upc_t U_RP_LOOP  = 5'd7;
    localparam upc_t U_RP_DROP  = 5'd8;
    localparam upc_t U_RB_LOOP  = 5'd9;
    localparam upc_t U_RB_DROP  = 5'd10;
    localparam upc_t U_RB_AT    = 5'd11;
    localparam upc_t U_RB_HUND  = 5'd12;
    localparam upc_t U_RB_TENS  = 5'd13;
    localparam upc_t U_RB_ONES  = 5'd14;
    localparam upc_t U_RB_SPACE = 5'd15;
    localparam upc_t U_COMMA    = 5'd16;
    localparam upc_t U_CM_LOOP  = 5'd17;
    localparam upc_t U_OP_LOOP  = 5'd18;
    localparam upc_t U_OP_PUSH  = 5'd19;
    localparam upc_t U_END      = 5'd20;
    localparam upc_t U_FLUSH    = 5'd21;
    localparam upc_t U_FIN      = 5'd22;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic alnum;
        logic in_operand;
        logic end_flag;
        logic empty;
        logic stop_paren;
        logic stop_brack;
        logic op_no_pop;
        logic arg_lt10;
        logic arg_lt100;
        logic stall;
        cls_t cls;
    } dp_stat_t;

    // one result transfer
    typedef struct packed {
        char_t ch;
        logic  has;
        logic  last;
        logic  done;
        logic  ovf;
    } res_t;

    function automatic cls_t classify(input char_t c);
        cls_t r;
        case (c) inside
            [CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ]: r = CLS_ALNUM;
            CH_LPAREN:                                 r = CLS_LPAREN;
            CH_LBRACK:                                 r = CLS_LBRACK;
            CH_RPAREN:                                 r = CLS_RPAREN;
            CH_RBRACK:                                 r = CLS_RBRACK;
            CH_COMMA:                                  r = CLS_COMMA;
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:      r = CLS_OP;
            default:                                   r = CLS_OTHER;
        endcase
        return r;
    endfunction

    function automatic op_code_t push_code_of(input char_t c);
        op_code_t r;
        case (c)
            CH_LPAREN: r = CODE_LPAREN;
            CH_LBRACK: r = CODE_LBRACK;
            CH_PLUS:   r = CODE_ADD;
            CH_MINUS:  r = CODE_SUB;
            CH_STAR:   r = CODE_MUL;
            default:   r = CODE_DIV;
        endcase
        return r;
    endfunction

    function automatic char_t code_char(input op_code_t code);
        char_t r;
        case (code)
            CODE_LPAREN: r = CH_LPAREN;
            CODE_LBRACK: r = CH_LBRACK;
            CODE_ADD:    r = CH_PLUS;
            CODE_SUB:    r = CH_MINUS;
            CODE_MUL:    r = CH_STAR;
            default:     r = CH_SLASH;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] code_prio(input op_code_t code);
        logic [1:0] r;
        case (code)
            CODE_LPAREN:        r = 2'd0;
            CODE_LBRACK:        r = 2'd1;
            CODE_ADD, CODE_SUB: r = 2'd2;
            default:            r = 2'd3;
        endcase
        return r;
    endfunction

    // double dabble: {hundreds, tens, ones}
    function automatic logic [11:0] to_bcd(input cnt_t v);
        logic [19:0] s;
        s = {12'd0, v};
        for (int i = 0; i < CNT_W; i++)
        begin
            if (s[11:8] > 4'd4)
                s[11:8] = s[11:8] + 4'd3;
            if (s[15:12] > 4'd4)
                s[15:12] = s[15:12] + 4'd3;
            if (s[19:16] > 4'd4)
                s[19:16] = s[19:16] + 4'd3;
            s = s << 1;
        end
        return s[19:8];
    endfunction

endpackage

// File: src/itp_if.sv
// Valid/ready channel interfaces for the converter's input and result transfers.
// Depends on itp_pkg.
interface itp_in_if;
    import itp_pkg::*;

    logic  valid;
    logic  ready;
    char_t in_char;
    logic  end_of_expr;

    modport source (output valid, output in_char, output end_of_expr, input ready);
    modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

interface itp_out_if;
    import itp_pkg::*;

    logic  valid;
    logic  ready;
    char_t out_char;
    logic  has_char;
    logic  last_of_run;
    logic  expr_done;
    logic  overflow;

    modport source (output valid, output out_char, output has_char, output last_of_run,
                    output expr_done, output overflow, input ready);
    modport sink   (input valid, input out_char, input has_char, input last_of_run,
                    input expr_done, input overflow, output ready);
endinterface

// File: src/itp_ucode_rom.sv
// Control store: the converter's microprogram, one control word per address.
// Depends on itp_pkg.
module itp_ucode_rom (
    input  itp_pkg::upc_t   upc,
    output itp_pkg::ucode_t uword
);
    import itp_pkg::*;

    function automatic ucode_t uw(input cond_t c, input upc_t t, input emit_t e,
                                  input act_t a, input nx_t n);
        ucode_t w;
        w.cond = c;
        w.tgt  = t;
        w.emit = e;
        w.act  = a;
        w.nx   = n;
        return w;
    endfunction

    always_comb
    begin
        case (upc)
            U_FETCH:    uword = uw(C_NO_INPUT,   U_FETCH,    E_NONE,  A_LOAD,       NX_INC);
            U_CLASSIFY: uword = uw(C_IS_ALNUM,   U_ALNUM,    E_NONE,  A_NONE,       NX_INC);
            U_RUNEND:   uword = uw(C_NOT_OPND,   U_DISPATCH, E_SPACE, A_RUNEND,     NX_INC);
            U_DISPATCH: uword = uw(C_NEVER,      U_END,      E_NONE,  A_NONE,       NX_DISPATCH);
            U_ALNUM:    uword = uw(C_NEVER,      U_END,      E_CHAR,  A_SET_OPND,   NX_GOTO);
            U_LPAREN:   uword = uw(C_NEVER,      U_END,      E_NONE,  A_PUSH,       NX_GOTO);
            U_LBRACK:   uword = uw(C_NEVER,      U_END,      E_NONE,  A_PUSH_LIST,  NX_GOTO);
            U_RP_LOOP:  uword = uw(C_STOP_PAREN, U_RP_DROP,  E_TOP,   A_POP,        NX_STAY);
            U_RP_DROP:  uword = uw(C_NEVER,      U_END,      E_NONE,  A_DROP_PAREN, NX_GOTO);
            U_RB_LOOP:  uword = uw(C_STOP_BRACK, U_RB_DROP,  E_TOP,   A_POP,        NX_STAY);
            U_RB_DROP:  uword = uw(C_NEVER,      U_RB_AT,    E_NONE,  A_DROP_BRACK, NX_INC);
            U_RB_AT:    uword = uw(C_NEVER,      U_RB_HUND,  E_AT,    A_NONE,       NX_INC);
            U_RB_HUND:  uword = uw(C_ARG_LT100,  U_RB_TENS,  E_HUND,  A_NONE,       NX_INC);
            U_RB_TENS:  uword = uw(C_ARG_LT10,   U_RB_ONES,  E_TENS,  A_NONE,       NX_INC);
            U_RB_ONES:  uword = uw(C_NEVER,      U_RB_SPACE, E_ONES,  A_NONE,       NX_INC);
            U_RB_SPACE: uword = uw(C_NEVER,      U_END,      E_SPACE, A_CLR_LIST,   NX_GOTO);
            U_COMMA:    uword = uw(C_NEVER,      U_CM_LOOP,  E_NONE,  A_ARG_INC,    NX_INC);
            U_CM_LOOP:  uword = uw(C_STOP_BRACK, U_END,      E_TOP,   A_POP,        NX_STAY);
            U_OP_LOOP:  uword = uw(C_OP_NO_POP,  U_OP_PUSH,  E_TOP,   A_POP,        NX_STAY);
            U_OP_PUSH:  uword = uw(C_NEVER,      U_END,      E_NONE,  A_PUSH,       NX_GOTO);
            U_END:      uword = uw(C_NOT_END,    U_FIN,      E_NONE,  A_NONE,       NX_INC);
            U_FLUSH:    uword = uw(C_EMPTY,      U_FIN,      E_TOP,   A_POP,        NX_STAY);
            U_FIN:      uword = uw(C_NEVER,      U_FETCH,    E_NONE,  A_FINISH,     NX_GOTO);
            default:    uword = uw(C_NEVER,      U_FETCH,    E_NONE,  A_NONE,       NX_GOTO);
        endcase
    end

endmodule

// File: src/itp_sequencer.sv
// Microcode sequencer: step counter, condition test, jumps and class dispatch.
// Depends on itp_pkg and itp_ucode_rom.
module itp_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  itp_pkg::dp_stat_t stat,
    output itp_pkg::ucode_t   uword,
    output logic              run,
    output logic              in_ready,
    output itp_pkg::upc_t     upc
);
    import itp_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_true;

    itp_ucode_rom u_rom (
        .upc   (upc_reg),
        .uword (uword)
    );

    function automatic upc_t dispatch(input cls_t c);
        upc_t r;
        case (c)
            CLS_LPAREN: r = U_LPAREN;
            CLS_LBRACK: r = U_LBRACK;
            CLS_RPAREN: r = U_RP_LOOP;
            CLS_RBRACK: r = U_RB_LOOP;
            CLS_COMMA:  r = U_COMMA;
            CLS_OP:     r = U_OP_LOOP;
            default:    r = U_END;
        endcase
        return r;
    endfunction

    always_comb
    begin
        case (uword.cond)
            C_NO_INPUT:   cond_true = !stat.in_valid;
            C_IS_ALNUM:   cond_true = stat.alnum;
            C_NOT_OPND:   cond_true = !stat.in_operand;
            C_STOP_PAREN: cond_true = stat.stop_paren;
            C_STOP_BRACK: cond_true = stat.stop_brack;
            C_ARG_LT100:  cond_true = stat.arg_lt100;
            C_ARG_LT10:   cond_true = stat.arg_lt10;
            C_OP_NO_POP:  cond_true = stat.op_no_pop;
            C_NOT_END:    cond_true = !stat.end_flag;
            C_EMPTY:      cond_true = stat.empty;
            default:      cond_true = 1'b0;
        endcase
    end

    assign run = !cond_true && !stat.stall;

    always_comb
    begin
        if (cond_true)
            upc_next = uword.tgt;
        else if (stat.stall)
            upc_next = upc_reg;
        else
        begin
            case (uword.nx)
                NX_INC:      upc_next = upc_t'(upc_reg + 1'b1);
                NX_STAY:     upc_next = upc_reg;
                NX_GOTO:     upc_next = uword.tgt;
                NX_DISPATCH: upc_next = dispatch(stat.cls);
                default:     upc_next = U_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= U_FETCH;
        else
            upc_reg <= upc_next;
    end

    assign in_ready = (upc_reg == U_FETCH);
    assign upc      = upc_reg;

endmodule

// File: src/itp_datapath.sv
// Datapath: operator stack, list and operand state, one-deep result holdback and
// the output register. Driven by control words from itp_sequencer; depends on itp_pkg.
module itp_datapath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
    parameter int LVL_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  itp_pkg::ucode_t   uword,
    input  logic              run,
    input  logic              in_valid,
    input  itp_pkg::char_t    in_char,
    input  logic              in_end,
    input  logic              out_ready,
    output logic              out_valid,
    output itp_pkg::res_t     out_res,
    output itp_pkg::dp_stat_t stat,
    output logic [LVL_W-1:0]  level
);
    import itp_pkg::*;

    localparam int IDX_W = $clog2(STACK_DEPTH);

    op_code_t stack_mem [STACK_DEPTH];

    logic [LVL_W-1:0] level_reg, level_next;
    cnt_t             arg_reg, arg_next;
    logic             in_list_reg, in_list_next;
    logic             opnd_reg, opnd_next;
    logic             ovf_reg, ovf_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;

    char_t            char_reg, char_next;
    logic             end_reg, end_next;
    char_t            pend_char_reg, pend_char_next;
    res_t             out_reg, out_next;
    op_code_t         top_reg;

    logic [LVL_W-1:0] level_dec;
    logic [LVL_W-1:0] level_next_dec;
    logic [IDX_W-1:0] rd_idx;
    op_code_t         top;
    op_code_t         push_code;
    logic             empty;
    logic             out_busy;
    logic [11:0]      arg_bcd;
    char_t            emit_char;
    logic             do_push;
    logic             stack_we;

    assign level_dec      = level_reg - LVL_W'(1);
    assign level_next_dec = level_next - LVL_W'(1);
    assign rd_idx         = level_next_dec[IDX_W-1:0];
    assign top            = top_reg;
    assign push_code      = push_code_of(char_reg);
    assign empty          = (level_reg == '0);
    assign out_busy       = out_valid_reg && !out_ready;
    assign arg_bcd        = to_bcd(arg_reg);

    always_comb
    begin
        stat.in_valid   = in_valid;
        stat.alnum      = (classify(char_reg) == CLS_ALNUM);
        stat.in_operand = opnd_reg;
        stat.end_flag   = end_reg;
        stat.empty      = empty;
        stat.stop_paren = empty || (top == CODE_LPAREN);
        stat.stop_brack = empty || (top == CODE_LBRACK);
        stat.op_no_pop  = empty || (code_prio(push_code) > code_prio(top));
        stat.arg_lt10   = (arg_reg < ARG_TEN);
        stat.arg_lt100  = (arg_reg < ARG_HUNDRED);
        stat.cls        = classify(char_reg);
        stat.stall      = out_busy &&
                          (((uword.emit != E_NONE) && pend_valid_reg) ||
                           ((uword.act == A_FINISH) && (pend_valid_reg || end_reg)));
    end

    always_comb
    begin
        case (uword.emit)
            E_CHAR:  emit_char = char_reg;
            E_SPACE: emit_char = CH_SPACE;
            E_TOP:   emit_char = code_char(top);
            E_AT:    emit_char = CH_AT;
            E_HUND:  emit_char = CH_0 + char_t'(arg_bcd[11:8]);
            E_TENS:  emit_char = CH_0 + char_t'(arg_bcd[7:4]);
            E_ONES:  emit_char = CH_0 + char_t'(arg_bcd[3:0]);
            default: emit_char = CH_NUL;
        endcase
    end

    always_comb
    begin
        level_next      = level_reg;
        arg_next        = arg_reg;
        in_list_next    = in_list_reg;
        opnd_next       = opnd_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        char_next       = char_reg;
        end_next        = end_reg;
        pend_char_next  = pend_char_reg;
        out_next        = out_reg;
        do_push         = 1'b0;
        stack_we        = 1'b0;

        if (run)
        begin
            if (uword.emit != E_NONE)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{ch: pend_char_reg, has: 1'b1, last: 1'b0,
                                       done: 1'b0, ovf: ovf_reg};
                end
                pend_char_next  = emit_char;
                pend_valid_next = 1'b1;
            end

            case (uword.act)
                A_LOAD:
                begin
                    char_next = in_char;
                    end_next  = in_end;
                end
                A_SET_OPND:
                    opnd_next = 1'b1;
                A_RUNEND:
                begin
                    opnd_next = 1'b0;
                    if (in_list_reg && (arg_reg == '0))
                        arg_next = cnt_t'(1);
                end
                A_PUSH:
                    do_push = 1'b1;
                A_PUSH_LIST:
                begin
                    in_list_next = 1'b1;
                    do_push      = 1'b1;
                end
                A_POP:
                    level_next = level_dec;
                A_DROP_PAREN:
                    if (!empty && (top == CODE_LPAREN))
                        level_next = level_dec;
                A_DROP_BRACK:
                    if (!empty && (top == CODE_LBRACK))
                        level_next = level_dec;
                A_CLR_LIST:
                begin
                    arg_next     = '0;
                    in_list_next = 1'b0;
                end
                A_ARG_INC:
                    if (arg_reg != ARG_MAX)
                        arg_next = arg_reg + cnt_t'(1);
                A_FINISH:
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{ch: pend_char_reg, has: 1'b1, last: 1'b1,
                                           done: end_reg, ovf: ovf_reg};
                    end
                    else if (end_reg)
                    begin
                        // marker transfer: nothing else came out of the closing byte
                        out_valid_next = 1'b1;
                        out_next       = '{ch: CH_NUL, has: 1'b0, last: 1'b1,
                                           done: 1'b1, ovf: ovf_reg};
                    end
                    pend_valid_next = 1'b0;
                    if (end_reg)
                    begin
                        level_next   = '0;
                        arg_next     = '0;
                        in_list_next = 1'b0;
                        opnd_next    = 1'b0;
                        ovf_next     = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase

            if (do_push)
            begin
                if (level_reg < LVL_W'(STACK_DEPTH))
                begin
                    stack_we   = 1'b1;
                    level_next = level_reg + LVL_W'(1);
                end
                else
                    ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            arg_reg        <= '0;
            in_list_reg    <= 1'b0;
            opnd_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            level_reg      <= level_next;
            arg_reg        <= arg_next;
            in_list_reg    <= in_list_next;
            opnd_reg       <= opnd_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // top of stack is read ahead into a register at the next level; a push bypasses the array
    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        end_reg       <= end_next;
        pend_char_reg <= pend_char_next;
        out_reg       <= out_next;
        if (stack_we)
            stack_mem[level_reg[IDX_W-1:0]] <= push_code;
        if (stack_we)
            top_reg <= push_code;
        else
            top_reg <= stack_mem[rd_idx];
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign level     = level_reg;

endmodule

// File: src/infix_to_postfix_converter_core.sv
// Top level of the infix to postfix converter; depends on itp_pkg, itp_if,
// itp_sequencer, itp_datapath and assert_macros.svh.
//
// Takes one byte of infix text per input transfer and returns the postfix bytes
// that byte causes, each as one result transfer; the last transfer of a byte has
// last_of_run set, and the byte flagged end_of_expr also flushes the operator
// stack, ends with expr_done and clears all state (a marker transfer with
// has_char low is sent if it gave nothing else). A small microprogram runs one
// control word per cycle unless the output stalls it, on a path of its own for a
// letter or digit, a dropped byte, '(' or '[', ')', ',' or an operator and ']',
// repeating a word for each stack pop or entry flushed. A new byte is accepted
// only once the previous one is finished. Result transfers leave through an
// output register with a one-result holdback, so a stalled consumer stalls the
// program only when both are full or an end marker meets a full output register.
// The operator stack holds STACK_DEPTH entries; a push onto a full stack is
// dropped and raises the sticky overflow flag for the expression.
`include "assert_macros.svh"

module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    itp_in_if.sink      char_in,
    itp_out_if.source   char_out
);
    import itp_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    ucode_t           uword;
    dp_stat_t         stat;
    logic             run;
    logic             in_ready;
    upc_t             upc;
    logic             out_valid;
    res_t             out_res;
    logic [LVL_W-1:0] stack_level;

    itp_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .uword    (uword),
        .run      (run),
        .in_ready (in_ready),
        .upc      (upc)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .LVL_W       (LVL_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .uword     (uword),
        .run       (run),
        .in_valid  (char_in.valid),
        .in_char   (char_in.in_char),
        .in_end    (char_in.end_of_expr),
        .out_ready (char_out.ready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .stat      (stat),
        .level     (stack_level)
    );

    assign char_in.ready        = in_ready;
    assign char_out.valid       = out_valid;
    assign char_out.out_char    = out_res.ch;
    assign char_out.has_char    = out_res.has;
    assign char_out.last_of_run = out_res.last;
    assign char_out.expr_done   = out_res.done;
    assign char_out.overflow    = out_res.ovf;

    `ASSERT_NEXT(a_accept_starts_program, char_in.valid && char_in.ready, upc != U_FETCH, "program did not start after input transfer")
    `ASSERT_HOLDS(a_level_in_range, stack_level <= LVL_W'(STACK_DEPTH), "stack level beyond depth")
    `ASSERT_IMPLIES(a_marker_closes_expr, char_out.valid && !char_out.has_char, char_out.last_of_run && char_out.expr_done, "marker transfer outside expression end")
    `ASSERT_IMPLIES(a_done_is_last, char_out.valid && char_out.expr_done, char_out.last_of_run, "expr_done without last_of_run")

endmodule
